### src/alst_pkg.sv
package alst_pkg;

    localparam int MODE_W   = 3;
    localparam int VERT_W   = 8;
    localparam int ORDER_W  = 9;
    localparam int LIMIT_W  = 5;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;
    localparam int EDGE_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_REM_ONE = 3'd1,
        MODE_REM_ALL = 3'd2,
        MODE_TEST    = 3'd3,
        MODE_CLEAR   = 3'd4,
        MODE_STATS   = 3'd5
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_VERTICES = 1'b0,
        REG_DEGREE_LIMIT = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD_DV,
        S_RD_DW,
        S_CHECK,
        S_ADD_V,
        S_ADD_W,
        S_FIND_RD,
        S_FIND_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_CLR,
        S_STATS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ORDER_W-1:0] num_vertices;
        logic [LIMIT_W-1:0] degree_limit;
    } t_cfg;

endpackage

### src/alst_if.sv
interface alst_req_if;
    logic                         valid;
    logic                         ready;
    logic [alst_pkg::MODE_W-1:0]  mode;
    logic [alst_pkg::VERT_W-1:0]  first_vertex;
    logic [alst_pkg::VERT_W-1:0]  second_vertex;

    modport source (output valid, mode, first_vertex, second_vertex, input ready);
    modport sink   (input valid, mode, first_vertex, second_vertex, output ready);
endinterface

interface alst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [alst_pkg::STAT_W-1:0]   status;
    logic                          hit;
    logic [alst_pkg::CNT_W-1:0]    removed_count;
    logic [alst_pkg::ORDER_W-1:0]  order;
    logic [alst_pkg::EDGE_W-1:0]   edge_count;
    logic [alst_pkg::CNT_W-1:0]    max_degree;
    logic [alst_pkg::CNT_W-1:0]    min_degree;

    modport source (output valid, status, hit, removed_count, order, edge_count,
                    max_degree, min_degree, input ready);
    modport sink   (input valid, status, hit, removed_count, order, edge_count,
                    max_degree, min_degree, output ready);
endinterface

interface alst_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [alst_pkg::CFG_IDX_W-1:0] index;
    logic [alst_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/alst_ram.sv
module alst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/alst_seq.sv
module alst_seq #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_DEGREE   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  alst_pkg::t_cfg i_cfg,
    alst_req_if.sink       i_req,
    alst_rsp_if.source     o_rsp
);
    import alst_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int NAW = $clog2(MAX_VERTICES * MAX_DEGREE);

    t_state               r_state, n_state;
    logic [MODE_W-1:0]    r_mode;
    logic [VERT_W-1:0]    r_v, r_w;
    logic [ORDER_W-1:0]   r_n;
    logic [DW-1:0]        r_lim, r_dv, r_dw, r_vi, r_wi, r_idx, r_removed;
    logic                 r_side, r_hit, r_pend, r_first;
    logic [STAT_W-1:0]    r_status;
    logic [EDGE_W-1:0]    r_edges;
    logic [ORDER_W-1:0]   r_j;
    logic [DW-1:0]        r_max, r_min;
    logic [VW-1:0]        r_clr;

    logic                 deg_we, nbr_we;
    logic [VW-1:0]        deg_waddr, deg_raddr;
    logic [DW-1:0]        deg_wdata, deg_rdata;
    logic [NAW-1:0]       nbr_waddr, nbr_raddr;
    logic [VERT_W-1:0]    nbr_wdata, nbr_rdata;

    logic [ORDER_W-1:0]   in_n;
    logic                 in_bad;
    logic [DW-1:0]        cur_deg;
    logic [VERT_W-1:0]    cur_vert, target;
    logic                 clr_last;

    function automatic logic [NAW-1:0] slot(input logic [VERT_W-1:0] vert,
                                            input logic [DW-1:0] pos);
        return NAW'(VW'(vert)) * NAW'(MAX_DEGREE) + NAW'(pos);
    endfunction

    alst_ram #(.DEPTH(MAX_VERTICES), .WIDTH(DW)) u_deg (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    alst_ram #(.DEPTH(MAX_VERTICES * MAX_DEGREE), .WIDTH(VERT_W)) u_nbr (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rdata)
    );

    assign in_n = (32'(i_cfg.num_vertices) > MAX_VERTICES) ? ORDER_W'(MAX_VERTICES)
                                                           : i_cfg.num_vertices;
    assign in_bad = (i_req.mode <= MODE_TEST)
                    && ((ORDER_W'(i_req.first_vertex) >= in_n)
                        || (ORDER_W'(i_req.second_vertex) >= in_n)
                        || (i_req.first_vertex == i_req.second_vertex));
    assign cur_deg  = r_side ? r_dw : r_dv;
    assign cur_vert = r_side ? r_w : r_v;
    assign target   = r_side ? r_v : r_w;
    assign clr_last = (r_clr == VW'(MAX_VERTICES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (in_bad) n_state = S_STATS;
                    else if (i_req.mode <= MODE_TEST) n_state = S_RD_DV;
                    else if (i_req.mode == MODE_CLEAR) n_state = S_CLR;
                    else n_state = S_STATS;
                end
            end
            S_RD_DV: n_state = S_RD_DW;
            S_RD_DW: n_state = S_CHECK;
            S_CHECK: begin
                if (r_mode != MODE_ADD) n_state = S_FIND_RD;
                else if (r_dv >= r_lim || deg_rdata >= r_lim) n_state = S_STATS;
                else n_state = S_ADD_V;
            end
            S_ADD_V: n_state = S_ADD_W;
            S_ADD_W: n_state = S_STATS;
            S_FIND_RD: begin
                if (r_idx >= cur_deg) n_state = S_STATS;
                else n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (nbr_rdata != target) n_state = S_FIND_RD;
                else if (r_mode == MODE_TEST) n_state = S_STATS;
                else if (!r_side) n_state = S_FIND_RD;
                else n_state = S_MOVE_RD;
            end
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: begin
                if (!r_side) n_state = S_MOVE_RD;
                else if (r_mode == MODE_REM_ONE) n_state = S_STATS;
                else n_state = S_FIND_RD;
            end
            S_CLR: begin
                if (clr_last) n_state = S_STATS;
            end
            S_STATS: begin
                if (r_j >= r_n && !r_pend) n_state = S_DONE;
            end
            S_DONE: begin
                if (!o_rsp.valid || o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        deg_we      = 1'b0;
        deg_waddr   = VW'(r_v);
        deg_wdata   = r_dv;
        deg_raddr   = VW'(r_j);
        nbr_we      = 1'b0;
        nbr_waddr   = slot(cur_vert, r_side ? r_wi : r_vi);
        nbr_wdata   = nbr_rdata;
        nbr_raddr   = slot(cur_vert, r_idx);
        unique case (r_state)
            S_INIT, S_CLR: begin
                deg_we    = 1'b1;
                deg_waddr = r_clr;
                deg_wdata = '0;
            end
            S_RD_DV: deg_raddr = VW'(r_v);
            S_RD_DW: deg_raddr = VW'(r_w);
            S_ADD_V: begin
                nbr_we    = 1'b1;
                nbr_waddr = slot(r_v, r_dv);
                nbr_wdata = r_w;
                deg_we    = 1'b1;
                deg_waddr = VW'(r_v);
                deg_wdata = r_dv + DW'(1);
            end
            S_ADD_W: begin
                nbr_we    = 1'b1;
                nbr_waddr = slot(r_w, r_dw);
                nbr_wdata = r_v;
                deg_we    = 1'b1;
                deg_waddr = VW'(r_w);
                deg_wdata = r_dw + DW'(1);
            end
            S_MOVE_RD: nbr_raddr = slot(cur_vert, cur_deg);
            S_MOVE_WR: begin
                nbr_we    = 1'b1;
                deg_we    = 1'b1;
                deg_waddr = VW'(cur_vert);
                deg_wdata = cur_deg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_edges     <= '0;
            o_rsp.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!o_rsp.valid || o_rsp.ready)) begin
                o_rsp.valid <= 1'b1;
            end else if (o_rsp.ready) begin
                o_rsp.valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: r_clr <= r_clr + VW'(1);
                S_IDLE: begin
                    r_mode    <= i_req.mode;
                    r_v       <= i_req.first_vertex;
                    r_w       <= i_req.second_vertex;
                    r_n       <= in_n;
                    r_lim     <= (32'(i_cfg.degree_limit) > MAX_DEGREE)
                                 ? DW'(MAX_DEGREE) : DW'(i_cfg.degree_limit);
                    r_status  <= in_bad ? ST_BAD : ST_OK;
                    r_hit     <= 1'b0;
                    r_removed <= '0;
                    r_side    <= 1'b0;
                    r_idx     <= '0;
                    r_clr     <= '0;
                end
                S_RD_DW: r_dv <= deg_rdata;
                S_CHECK: begin
                    r_dw <= deg_rdata;
                    if (r_mode == MODE_ADD && (r_dv >= r_lim || deg_rdata >= r_lim)) begin
                        r_status <= ST_OVERFLOW;
                    end
                end
                S_ADD_W: r_edges <= r_edges + EDGE_W'(1);
                S_FIND_RD: begin
                    if (r_idx >= cur_deg) begin
                        r_hit    <= (r_removed != '0);
                        r_status <= (r_removed != '0) ? ST_OK : ST_NOT_FOUND;
                    end
                end
                S_FIND_CMP: begin
                    if (nbr_rdata != target) begin
                        r_idx <= r_idx + DW'(1);
                    end else if (r_mode == MODE_TEST) begin
                        r_hit <= 1'b1;
                    end else if (!r_side) begin
                        r_vi   <= r_idx;
                        r_side <= 1'b1;
                        r_idx  <= '0;
                    end else begin
                        r_wi   <= r_idx;
                        r_dv   <= r_dv - DW'(1);
                        r_dw   <= r_dw - DW'(1);
                        r_side <= 1'b0;
                    end
                end
                S_MOVE_WR: begin
                    if (!r_side) begin
                        r_side <= 1'b1;
                    end else begin
                        if (r_edges != '0) r_edges <= r_edges - EDGE_W'(1);
                        r_removed <= r_removed + DW'(1);
                        r_side    <= 1'b0;
                        r_idx     <= '0;
                        r_hit     <= 1'b1;
                        r_status  <= ST_OK;
                    end
                end
                S_CLR: begin
                    r_clr   <= r_clr + VW'(1);
                    r_edges <= '0;
                end
                S_STATS: begin
                    if (r_pend) begin
                        r_first <= 1'b0;
                        if (deg_rdata > r_max) r_max <= deg_rdata;
                        if (r_first || deg_rdata < r_min) r_min <= deg_rdata;
                    end
                    r_pend <= (r_j < r_n);
                    if (r_j < r_n) r_j <= r_j + ORDER_W'(1);
                end
                default: ;
            endcase
            if (n_state == S_STATS && r_state != S_STATS) begin
                r_j     <= '0;
                r_pend  <= 1'b0;
                r_first <= 1'b1;
                r_max   <= '0;
                r_min   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!o_rsp.valid || o_rsp.ready)) begin
            o_rsp.status        <= r_status;
            o_rsp.hit           <= r_hit;
            o_rsp.removed_count <= CNT_W'(r_removed);
            o_rsp.order         <= r_n;
            o_rsp.edge_count    <= r_edges;
            o_rsp.max_degree    <= CNT_W'(r_max);
            o_rsp.min_degree    <= CNT_W'(r_min);
        end
    end
endmodule

### src/adjacency_list_store.sv
// Channel   Direction  Contents
// i_req     in         mode, first_vertex, second_vertex
// o_rsp     out        status, hit, removed_count, order, edge_count, max/min degree
// i_cfg     in         register index and write data
//
// An add reads both degrees, checks the limit and appends to both lists; a search reads
// each list entry visited, and a removed copy is overwritten by each list's last entry.
// Every request ends with a statistics pass over the degree memory, one vertex per cycle.
// A clear and the pass after reset each sweep the whole degree memory.
// Reset is synchronous; the request channel is not ready during the sweep.
// A pending response does not stop the next request from being taken.
module adjacency_list_store #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_DEGREE   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alst_req_if.sink   i_req,
    alst_rsp_if.source o_rsp,
    alst_cfg_if.sink   i_cfg
);
    import alst_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_vertices <= '0;
            r_cfg.degree_limit <= LIMIT_W'(16);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NUM_VERTICES: r_cfg.num_vertices <= i_cfg.data;
                REG_DEGREE_LIMIT: r_cfg.degree_limit <= i_cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    alst_seq #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_deg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.max_degree >= o_rsp.min_degree)
        else $error("maximum degree below minimum degree");
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_BAD) |-> (!o_rsp.hit && o_rsp.removed_count == '0))
        else $error("rejected request reports a hit");
    a_removed_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.removed_count != '0) |-> (o_rsp.hit && o_rsp.status == ST_OK))
        else $error("removal without hit");
    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.order == '0) |-> (o_rsp.max_degree == '0))
        else $error("degree reported for empty order");
`endif
endmodule

### tb/tb_top.sv
module tb_top;
    import alst_pkg::*;

    localparam int NV = 256;
    localparam int ND = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    alst_req_if req_ch ();
    alst_rsp_if rsp_ch ();
    alst_cfg_if cfg_ch ();

    adjacency_list_store uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .i_cfg  (cfg_ch)
    );

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               hit;
        logic [CNT_W-1:0]   removed_count;
        logic [ORDER_W-1:0] order;
        logic [EDGE_W-1:0]  edge_count;
        logic [CNT_W-1:0]   max_degree;
        logic [CNT_W-1:0]   min_degree;
    } t_graph_result;

    logic [VERT_W-1:0]  nbr_list [NV][ND];
    logic [CNT_W-1:0]   vert_degree [NV];
    logic [EDGE_W-1:0]  stored_edges;
    logic [ORDER_W-1:0] cfg_vertices;
    logic [LIMIT_W-1:0] cfg_limit;

    t_graph_result pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  requests_sent = 0;
    int  mode_seen [8];
    int  status_seen [4];
    bit  hold_off = 1'b0;

    function automatic int list_pos(int u, int x);
        int i;
        for (i = 0; i < vert_degree[u]; i++)
            if (nbr_list[u][i] == x) return i;
        return vert_degree[u];
    endfunction

    function automatic bit drop_edge_copy(int v, int w);
        int vi;
        int wi;
        vi = list_pos(v, w);
        if (vi >= vert_degree[v]) return 1'b0;
        wi = list_pos(w, v);
        if (wi >= vert_degree[w]) return 1'b0;
        vert_degree[v]--;
        vert_degree[w]--;
        nbr_list[v][vi] = nbr_list[v][vert_degree[v]];
        nbr_list[w][wi] = nbr_list[w][vert_degree[w]];
        if (stored_edges > 0) stored_edges--;
        return 1'b1;
    endfunction

    function automatic t_graph_result apply_graph_op(logic [MODE_W-1:0] md, int v, int w);
        t_graph_result r;
        int n;
        int lim;
        int i;
        r = '0;
        n = (cfg_vertices > NV) ? NV : cfg_vertices;
        lim = (cfg_limit > ND) ? ND : cfg_limit;
        if (md <= MODE_TEST && (v >= n || w >= n || v == w)) begin
            r.status = ST_BAD;
        end else if (md == MODE_ADD) begin
            if (vert_degree[v] + 1 > lim || vert_degree[w] + 1 > lim) begin
                r.status = ST_OVERFLOW;
            end else begin
                nbr_list[v][vert_degree[v]] = VERT_W'(w);
                nbr_list[w][vert_degree[w]] = VERT_W'(v);
                vert_degree[v]++;
                vert_degree[w]++;
                stored_edges++;
                r.status = ST_OK;
            end
        end else if (md == MODE_REM_ONE || md == MODE_REM_ALL) begin
            while (drop_edge_copy(v, w)) begin
                r.removed_count++;
                if (md == MODE_REM_ONE) break;
            end
            r.hit = (r.removed_count != 0);
            r.status = r.hit ? ST_OK : ST_NOT_FOUND;
        end else if (md == MODE_TEST) begin
            r.hit = list_pos(v, w) < vert_degree[v];
            r.status = r.hit ? ST_OK : ST_NOT_FOUND;
        end else if (md == MODE_CLEAR) begin
            for (i = 0; i < NV; i++) vert_degree[i] = '0;
            stored_edges = '0;
        end
        r.order = ORDER_W'(n);
        r.edge_count = stored_edges;
        if (n > 0) begin
            r.min_degree = vert_degree[0];
            for (i = 0; i < n; i++) begin
                if (vert_degree[i] > r.max_degree) r.max_degree = vert_degree[i];
                if (vert_degree[i] < r.min_degree) r.min_degree = vert_degree[i];
            end
        end
        return r;
    endfunction

    task automatic send_request(logic [MODE_W-1:0] md, int v, int w);
        req_ch.valid <= 1'b1;
        req_ch.mode <= md;
        req_ch.first_vertex <= VERT_W'(v);
        req_ch.second_vertex <= VERT_W'(w);
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(apply_graph_op(md, v, w));
        mode_seen[md]++;
        requests_sent++;
    endtask

    task automatic pause_sender();
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic paced_request(logic [MODE_W-1:0] md, int v, int w);
        send_request(md, v, w);
        if ($urandom_range(0, 3) == 0) pause_sender();
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NV + 40) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg idx, int value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= CFG_DAT_W'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_NUM_VERTICES) cfg_vertices = ORDER_W'(value);
        else cfg_limit = LIMIT_W'(value);
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        write_register(REG_NUM_VERTICES, 0);
        send_request(MODE_STATS, 0, 1);
        send_request(MODE_ADD, 0, 1);
        write_register(REG_NUM_VERTICES, 256);
        send_request(MODE_ADD, 0, 255);
        send_request(MODE_ADD, 255, 0);
        send_request(MODE_ADD, 7, 7);
        send_request(MODE_TEST, 0, 255);
        send_request(MODE_TEST, 1, 2);
        send_request(MODE_REM_ONE, 255, 0);
        send_request(MODE_REM_ALL, 0, 255);
        send_request(MODE_REM_ALL, 0, 255);
        send_request(MODE_CLEAR, 170, 85);
        send_request(3'd6, 0, 0);
        send_request(3'd7, 255, 255);
        write_register(REG_DEGREE_LIMIT, 1);
        send_request(MODE_ADD, 1, 2);
        send_request(MODE_ADD, 1, 3);
        write_register(REG_DEGREE_LIMIT, 0);
        send_request(MODE_ADD, 4, 5);
        write_register(REG_DEGREE_LIMIT, 31);
        send_request(MODE_ADD, 1, 3);
        write_register(REG_NUM_VERTICES, 511);
        send_request(MODE_STATS, 0, 0);
        write_register(REG_NUM_VERTICES, 2);
        send_request(MODE_ADD, 1, 3);
        send_request(MODE_STATS, 0, 0);
    endtask

    task automatic random_phase(int count, int order_val, int limit_val);
        int k;
        int v;
        int w;
        int sel;
        logic [MODE_W-1:0] md;
        write_register(REG_NUM_VERTICES, order_val);
        write_register(REG_DEGREE_LIMIT, limit_val);
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) md = MODE_ADD;
            else if (sel < 55) md = MODE_REM_ONE;
            else if (sel < 65) md = MODE_REM_ALL;
            else if (sel < 85) md = MODE_TEST;
            else if (sel < 88) md = MODE_CLEAR;
            else md = $urandom_range(5, 7);
            if ($urandom_range(0, 15) == 0) begin
                v = $urandom_range(0, 255);
                w = $urandom_range(0, 255);
            end else begin
                v = $urandom_range(0, (order_val > 1 ? order_val : 2) - 1);
                w = $urandom_range(0, (order_val > 1 ? order_val : 2) - 1);
            end
            paced_request(md, v, w);
        end
    endtask

    task automatic test_backpressure();
        int k;
        fork
            begin
                hold_off <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                for (k = 0; k < 20; k++) send_request(MODE_TEST, k % 8, (k + 1) % 8);
            end
        join
        drain_results();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.mode = '0;
        req_ch.first_vertex = '0;
        req_ch.second_vertex = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_NUM_VERTICES;
        cfg_ch.data = '0;
        for (int i = 0; i < NV; i++) vert_degree[i] = '0;
        stored_edges = '0;
        cfg_vertices = '0;
        cfg_limit = 5'd16;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        random_phase(300, 8, 16);
        random_phase(200, 4, 3);
        test_backpressure();
        random_phase(200, 64, 5);
        random_phase(150, 256, 16);
        random_phase(150, 3, 2);
        drain_results();
        $display("Sent %0d requests, %0d results checked; adds %0d, removals %0d, tests %0d.",
                 requests_sent, results_seen, mode_seen[MODE_ADD],
                 mode_seen[MODE_REM_ONE] + mode_seen[MODE_REM_ALL], mode_seen[MODE_TEST]);
        $display("Status counts ok/absent/overflow/bad: %0d %0d %0d %0d.", status_seen[ST_OK],
                 status_seen[ST_NOT_FOUND], status_seen[ST_OVERFLOW], status_seen[ST_BAD]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    int stall_phase = 0;

    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_off) begin
            rsp_ch.ready <= 1'b0;
        end else if (stall_phase % 64 < 32) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_graph_result got;
        t_graph_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.status, rsp_ch.hit, rsp_ch.removed_count, rsp_ch.order,
                    rsp_ch.edge_count, rsp_ch.max_degree, rsp_ch.min_degree};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected %p, got %p", results_seen, want, got);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
